FILE: rtl/tsb_pkg.sv
`timescale 1ns / 1ps
package tsb_pkg;
  localparam int SLOTS = 16;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QDEPTH = 2;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_ARM     = 3'd1;
  localparam logic [2:0] CMD_CANCEL  = 3'd2;
  localparam logic [2:0] CMD_FORCE   = 3'd3;
  localparam logic [2:0] CMD_RESTART = 3'd4;
  localparam logic [2:0] CMD_QUERY   = 3'd5;
  localparam logic [2:0] CMD_RUN     = 3'd6;
  localparam logic [2:0] CMD_BAD     = 3'd7;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  slot;
    logic [31:0] period;
    logic        repeat_req;
    logic        valid_slot;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic        fired;
    logic [3:0]  fired_slot;
    logic [31:0] elapsed;
    logic [31:0] remaining;
    logic        active;
    logic        last;
  } res_t;
endpackage

FILE: rtl/tsb_front.sv
`timescale 1ns / 1ps
module tsb_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [39:0]   in_tdata,
  output logic          q_valid,
  input  logic          q_ready,
  output tsb_pkg::cmd_t q_cmd
);
  tsb_pkg::cmd_t q_r [tsb_pkg::QDEPTH];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  tsb_pkg::cmd_t c;
  logic          push, pop;

  always_comb begin
    c.command    = in_tdata[2:0];
    c.slot       = in_tdata[6:3];
    c.period     = in_tdata[38:7];
    c.repeat_req = in_tdata[39];
    c.valid_slot = ({28'd0, in_tdata[6:3]} < 32'(tsb_pkg::SLOTS));
  end

  assign in_tready = (cnt_r != 2'(tsb_pkg::QDEPTH));
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        q_r[wp_r] <= c;
        wp_r <= ~wp_r;
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: rtl/tsb_back.sv
`timescale 1ns / 1ps
module tsb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  tsb_pkg::cmd_t q_cmd,
  output logic          out_tvalid,
  input  logic          out_tready,
  output tsb_pkg::res_t out_res
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PEND} state_t;

  state_t state_r;
  logic [31:0] tick_r, now_r;
  logic [31:0] start_r [tsb_pkg::SLOTS];
  logic [31:0] delay_r [tsb_pkg::SLOTS];
  logic [tsb_pkg::SLOTS-1:0] armed_r, canc_r, cyc_r;
  logic [tsb_pkg::SW-1:0] idx_r;
  logic        any_r;
  logic        pend_v_r;
  tsb_pkg::res_t pend_r;
  logic        ov_r;
  tsb_pkg::res_t res_r;

  logic [tsb_pkg::SW-1:0] s;
  logic [31:0] el, diff;
  logic        due;

  assign s = q_cmd.slot[tsb_pkg::SW-1:0];
  assign el = tick_r - start_r[s];
  assign diff = now_r - start_r[idx_r];
  assign due = armed_r[idx_r] && !canc_r[idx_r] && (diff >= delay_r[idx_r]);
  assign out_tvalid = ov_r;
  assign out_res = res_r;
  assign q_ready = (state_r == S_IDLE) && (!ov_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tick_r <= '0;
      armed_r <= '0;
      canc_r <= '0;
      cyc_r <= '0;
      ov_r <= 1'b0;
      pend_v_r <= 1'b0;
      any_r <= 1'b0;
      idx_r <= '0;
      for (int i = 0; i < tsb_pkg::SLOTS; i++) begin
        start_r[i] <= '0;
        delay_r[i] <= '0;
      end
    end else begin
      if (ov_r && out_tready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            ov_r <= 1'b1;
            res_r <= '0;
            res_r.last <= 1'b1;
            res_r.ok <= 1'b1;
            if (q_cmd.command == tsb_pkg::CMD_TICK) begin
              tick_r <= tick_r + 32'd1;
            end else if (q_cmd.command == tsb_pkg::CMD_RUN) begin
              ov_r <= 1'b0;
              now_r <= tick_r;
              idx_r <= tsb_pkg::SW'(tsb_pkg::SLOTS - 1);
              any_r <= 1'b0;
              pend_v_r <= 1'b0;
              state_r <= S_SCAN;
            end else if (q_cmd.command == tsb_pkg::CMD_BAD || !q_cmd.valid_slot) begin
              res_r.ok <= 1'b0;
              if (q_cmd.command == tsb_pkg::CMD_QUERY) res_r.fired_slot <= q_cmd.slot;
            end else begin
              case (q_cmd.command)
                tsb_pkg::CMD_ARM: begin
                  if (q_cmd.period == 32'd0) begin
                    res_r.ok <= 1'b0;
                  end else begin
                    canc_r[s] <= 1'b0;
                    cyc_r[s] <= q_cmd.repeat_req;
                    delay_r[s] <= q_cmd.period;
                    start_r[s] <= tick_r;
                    armed_r[s] <= 1'b1;
                  end
                end
                tsb_pkg::CMD_CANCEL:  canc_r[s] <= 1'b1;
                tsb_pkg::CMD_FORCE:   start_r[s] <= start_r[s] - delay_r[s];
                tsb_pkg::CMD_RESTART: start_r[s] <= tick_r;
                tsb_pkg::CMD_QUERY: begin
                  res_r.fired_slot <= q_cmd.slot;
                  if (armed_r[s] && !canc_r[s]) begin
                    res_r.active <= 1'b1;
                    res_r.elapsed <= el;
                    res_r.remaining <= delay_r[s] - el;
                  end else begin
                    res_r.elapsed <= delay_r[s];
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_SCAN: begin
          if (!pend_v_r || !ov_r || out_tready) begin
            // emit held result once a newer one exists (so last is known)
            if (due && pend_v_r) begin
              res_r <= pend_r;
              ov_r <= 1'b1;
            end
            if (armed_r[idx_r] && canc_r[idx_r]) begin
              armed_r[idx_r] <= 1'b0;
              canc_r[idx_r] <= 1'b0;
              cyc_r[idx_r] <= 1'b0;
            end else if (due) begin
              if (cyc_r[idx_r]) start_r[idx_r] <= now_r;
              else begin
                armed_r[idx_r] <= 1'b0;
                cyc_r[idx_r] <= 1'b0;
              end
              pend_r <= '0;
              pend_r.ok <= 1'b1;
              pend_r.fired <= 1'b1;
              pend_r.fired_slot <= 4'(idx_r);
              pend_v_r <= 1'b1;
              any_r <= 1'b1;
            end
            if (idx_r == '0) state_r <= S_PEND;
            else idx_r <= idx_r - 1'b1;
          end
        end
        S_PEND: begin
          if (!ov_r || out_tready) begin
            ov_r <= 1'b1;
            res_r <= '0;
            res_r.ok <= 1'b1;
            res_r.last <= 1'b1;
            if (any_r) begin
              res_r <= pend_r;
              res_r.last <= 1'b1;
            end
            pend_v_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/timer_slot_bank_top.sv
`timescale 1ns / 1ps
// channel | dir | tdata fields (low bit up)
// in_     | in  | command[2:0] slot[6:3] period[38:7] repeat_req[39]
// out_    | out | ok fired fired_slot[5:2] elapsed[37:6] remaining[69:38] active[70]; tlast=last
// Slot commands and tick pass through the two-entry command queue and the single output
// register. Run: one slot examined per cycle by the back-end scanner while no held fired
// result waits on a stalled output. Reset synchronous, active low, clears all timer state.
// Such stalls hold the scanner; the queue keeps taking commands until full.
module timer_slot_bank_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // command, slot, period, repeat_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // ok, fired, fired_slot, elapsed, remaining, active
  output logic        out_tlast
);
  logic          q_valid, q_ready;
  tsb_pkg::cmd_t q_cmd;
  tsb_pkg::res_t res;

  tsb_front u_front (.clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
                     .q_valid, .q_ready, .q_cmd);
  tsb_back u_back (.clk, .rst_n, .q_valid, .q_ready, .q_cmd,
                   .out_tvalid, .out_tready, .out_res(res));

  assign out_tdata = {1'b0, res.active, res.remaining, res.elapsed,
                      res.fired_slot, res.fired, res.ok};
  assign out_tlast = res.last;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");
  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[1] && out_tdata[0])
    else $error("non-final result not a fired slot");
endmodule

FILE: bench/timer_slot_bank_checker.sv
`timescale 1ns / 1ps
module timer_slot_bank_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending,
  output int          fired_seen,
  output int          results_seen
);
  logic [31:0]   tick_now;
  logic [31:0]   slot_start [tsb_pkg::SLOTS];
  logic [31:0]   slot_delay [tsb_pkg::SLOTS];
  logic          slot_armed [tsb_pkg::SLOTS];
  logic          slot_cancel [tsb_pkg::SLOTS];
  logic          slot_cyclic [tsb_pkg::SLOTS];
  tsb_pkg::res_t expected_results [$];

  task automatic push_result(input logic ok, input logic fired, input logic [3:0] fslot,
                             input logic [31:0] el, input logic [31:0] rem,
                             input logic act, input logic lst);
    tsb_pkg::res_t r;
    r.ok = ok; r.fired = fired; r.fired_slot = fslot; r.elapsed = el;
    r.remaining = rem; r.active = act; r.last = lst;
    expected_results.push_back(r);
  endtask

  task automatic apply_command(input logic [39:0] d);
    logic [2:0]  cmd;
    logic [3:0]  s;
    logic [31:0] per;
    logic        rep;
    logic [31:0] el;
    int          n;
    cmd = d[2:0]; s = d[6:3]; per = d[38:7]; rep = d[39];
    n = 0;
    if (cmd == tsb_pkg::CMD_TICK) begin
      tick_now = tick_now + 32'd1;
      push_result(1'b1, 1'b0, 4'd0, 32'd0, 32'd0, 1'b0, 1'b1);
    end else if (cmd == tsb_pkg::CMD_RUN) begin
      for (int i = tsb_pkg::SLOTS - 1; i >= 0; i--) begin
        if (!slot_armed[i]) continue;
        if (slot_cancel[i]) begin
          slot_armed[i] = 1'b0; slot_cancel[i] = 1'b0; slot_cyclic[i] = 1'b0;
          continue;
        end
        if (tick_now - slot_start[i] >= slot_delay[i]) begin
          if (slot_cyclic[i]) slot_start[i] = tick_now;
          else begin
            slot_armed[i] = 1'b0; slot_cancel[i] = 1'b0; slot_cyclic[i] = 1'b0;
          end
          push_result(1'b1, 1'b1, 4'(i), 32'd0, 32'd0, 1'b0, 1'b0);
          n++;
        end
      end
      if (n == 0) push_result(1'b1, 1'b0, 4'd0, 32'd0, 32'd0, 1'b0, 1'b1);
      else expected_results[$].last = 1'b1;
    end else if (cmd == tsb_pkg::CMD_BAD || int'(s) >= tsb_pkg::SLOTS) begin
      push_result(1'b0, 1'b0, (cmd == tsb_pkg::CMD_QUERY) ? s : 4'd0, 32'd0, 32'd0,
                  1'b0, 1'b1);
    end else if (cmd == tsb_pkg::CMD_ARM && per == 32'd0) begin
      push_result(1'b0, 1'b0, 4'd0, 32'd0, 32'd0, 1'b0, 1'b1);
    end else if (cmd == tsb_pkg::CMD_QUERY) begin
      if (slot_armed[s] && !slot_cancel[s]) begin
        el = tick_now - slot_start[s];
        push_result(1'b1, 1'b0, s, el, slot_delay[s] - el, 1'b1, 1'b1);
      end else begin
        push_result(1'b1, 1'b0, s, slot_delay[s], 32'd0, 1'b0, 1'b1);
      end
    end else begin
      case (cmd)
        tsb_pkg::CMD_ARM: begin
          slot_cancel[s] = 1'b0; slot_cyclic[s] = rep; slot_delay[s] = per;
          slot_start[s] = tick_now; slot_armed[s] = 1'b1;
        end
        tsb_pkg::CMD_CANCEL:  slot_cancel[s] = 1'b1;
        tsb_pkg::CMD_FORCE:   slot_start[s] = slot_start[s] - slot_delay[s];
        tsb_pkg::CMD_RESTART: slot_start[s] = tick_now;
        default: ;
      endcase
      push_result(1'b1, 1'b0, 4'd0, 32'd0, 32'd0, 1'b0, 1'b1);
    end
  endtask

  task automatic compare_result(input tsb_pkg::res_t e);
    if (out_tdata[0] !== e.ok)
      $error("ok: expected %0d got %0d", e.ok, out_tdata[0]);
    if (out_tdata[1] !== e.fired)
      $error("fired: expected %0d got %0d", e.fired, out_tdata[1]);
    if (out_tdata[5:2] !== e.fired_slot)
      $error("fired_slot: expected %0d got %0d", e.fired_slot, out_tdata[5:2]);
    if (out_tdata[37:6] !== e.elapsed)
      $error("elapsed: expected %0h got %0h", e.elapsed, out_tdata[37:6]);
    if (out_tdata[69:38] !== e.remaining)
      $error("remaining: expected %0h got %0h", e.remaining, out_tdata[69:38]);
    if (out_tdata[70] !== e.active)
      $error("active: expected %0d got %0d", e.active, out_tdata[70]);
    if (out_tlast !== e.last)
      $error("last: expected %0d got %0d", e.last, out_tlast);
    if (out_tdata[0] !== e.ok || out_tdata[1] !== e.fired || out_tdata[5:2] !== e.fired_slot ||
        out_tdata[37:6] !== e.elapsed || out_tdata[69:38] !== e.remaining ||
        out_tdata[70] !== e.active || out_tlast !== e.last)
      fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tick_now = '0;
      for (int i = 0; i < tsb_pkg::SLOTS; i++) begin
        slot_start[i] = '0; slot_delay[i] = '0;
        slot_armed[i] = 1'b0; slot_cancel[i] = 1'b0; slot_cyclic[i] = 1'b0;
      end
      expected_results.delete();
      fail_count = 0;
      pending = 0;
      fired_seen <= 0;
      results_seen <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (out_tdata[1] === 1'b1) fired_seen <= fired_seen + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: %0h", out_tdata);
          fail_count++;
        end else begin
          compare_result(expected_results.pop_front());
        end
      end
      if (in_tvalid && in_tready) apply_command(in_tdata);
      pending = expected_results.size();
    end
  end
endmodule

FILE: bench/timer_slot_bank_top_tb.sv
`timescale 1ns / 1ps
module timer_slot_bank_top_tb;
  localparam int WATCHDOG = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;
  logic        out_tlast;
  int          fail_count, pending, fired_seen, results_seen;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off = 0;
  int          items_sent = 0;
  int          quiet_cycles = 0;

  always #10 clk = ~clk;

  timer_slot_bank_top dut (.*);

  timer_slot_bank_checker chk (.*);

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (hold_off) out_tready <= 0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(input logic [2:0] cmd, input logic [3:0] s, input logic [31:0] per,
                      input logic rep);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {rep, per, s, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic stop_sending();
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    stop_sending();
    while (pending != 0) @(posedge clk);
    repeat (tsb_pkg::SLOTS + 10) @(posedge clk);
  endtask

  task automatic send_random();
    int k;
    logic [31:0] per;
    k = $urandom_range(99);
    case ($urandom_range(3))
      0: per = $urandom;
      1: per = 32'hFFFF_FFF0 | 32'($urandom_range(15));
      default: per = 32'($urandom_range(1, 6));
    endcase
    if (k < 25) send(tsb_pkg::CMD_TICK, 4'($urandom), $urandom, 1'($urandom));
    else if (k < 45)
      send(tsb_pkg::CMD_ARM, 4'($urandom), (k == 26) ? 32'd0 : per, 1'($urandom));
    else if (k < 52) send(tsb_pkg::CMD_CANCEL, 4'($urandom), $urandom, 1'($urandom));
    else if (k < 59) send(tsb_pkg::CMD_FORCE, 4'($urandom), $urandom, 1'($urandom));
    else if (k < 65) send(tsb_pkg::CMD_RESTART, 4'($urandom), $urandom, 1'($urandom));
    else if (k < 80) send(tsb_pkg::CMD_QUERY, 4'($urandom), $urandom, 1'($urandom));
    else if (k < 97) send(tsb_pkg::CMD_RUN, 4'($urandom), $urandom, 1'($urandom));
    else send(tsb_pkg::CMD_BAD, 4'($urandom), $urandom, 1'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty run, zero period, extremes, cancel/force/restart on idle slots
    send(tsb_pkg::CMD_RUN, 4'd0, 32'd0, 1'b0);
    send(tsb_pkg::CMD_ARM, 4'd15, 32'd0, 1'b1);
    send(tsb_pkg::CMD_QUERY, 4'd15, 32'd0, 1'b0);
    send(tsb_pkg::CMD_ARM, 4'd15, 32'hFFFF_FFFF, 1'b1);
    send(tsb_pkg::CMD_ARM, 4'd0, 32'd1, 1'b0);
    send(tsb_pkg::CMD_ARM, 4'd7, 32'd2, 1'b1);
    send(tsb_pkg::CMD_QUERY, 4'd0, 32'd0, 1'b0);
    send(tsb_pkg::CMD_TICK, 4'd15, 32'hFFFF_FFFF, 1'b1);
    send(tsb_pkg::CMD_TICK, 4'd0, 32'd0, 1'b0);
    send(tsb_pkg::CMD_RUN, 4'd0, 32'd0, 1'b0);
    send(tsb_pkg::CMD_QUERY, 4'd7, 32'd0, 1'b0);
    send(tsb_pkg::CMD_FORCE, 4'd15, 32'd0, 1'b0);
    send(tsb_pkg::CMD_QUERY, 4'd15, 32'd0, 1'b0);
    send(tsb_pkg::CMD_RUN, 4'd0, 32'd0, 1'b0);
    send(tsb_pkg::CMD_CANCEL, 4'd7, 32'd0, 1'b0);
    send(tsb_pkg::CMD_CANCEL, 4'd3, 32'd0, 1'b0);
    send(tsb_pkg::CMD_FORCE, 4'd4, 32'd0, 1'b0);
    send(tsb_pkg::CMD_RESTART, 4'd5, 32'd0, 1'b0);
    send(tsb_pkg::CMD_ARM, 4'd7, 32'd5, 1'b0);
    send(tsb_pkg::CMD_RESTART, 4'd7, 32'd0, 1'b0);
    send(tsb_pkg::CMD_RUN, 4'd0, 32'd0, 1'b0);
    send(tsb_pkg::CMD_BAD, 4'd9, 32'hFFFF_FFFF, 1'b1);
    send(tsb_pkg::CMD_QUERY, 4'd7, 32'd0, 1'b0);
    drain();

    // long receiver hold-off while commands keep coming
    hold_off = 1;
    fork
      begin
        for (int i = 0; i < tsb_pkg::SLOTS; i++) send(tsb_pkg::CMD_ARM, 4'(i), 32'd1, 1'(i));
        send(tsb_pkg::CMD_TICK, 4'd0, 32'd0, 1'b0);
        send(tsb_pkg::CMD_RUN, 4'd0, 32'd0, 1'b0);
        send(tsb_pkg::CMD_RUN, 4'd0, 32'd0, 1'b0);
        stop_sending();
      end
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
    join
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int i = 0; i < 45; i++) send_random();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();

    $display("Sent %0d commands, checked %0d results, %0d slot expirations.",
             items_sent, results_seen, fired_seen);
    $display("Covered arm/cancel/force/restart/query/run/tick, bad command, stalls.");
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
